@@ rtl/core/pending_interest_table_top_macros.svh @@
// Assertion macros for the pending request table.
`ifndef PENDING_INTEREST_TABLE_TOP_MACROS_SVH
`define PENDING_INTEREST_TABLE_TOP_MACROS_SVH

// Same-cycle implication.
`define PIT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/pit_pkg.sv @@
// Shared types and codes of the pending request table.
`timescale 1ns / 1ps
package pit_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int CMP_W = 64;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_SWEEP  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_NEW          = 4'd0,
		ST_AGGREGATED   = 4'd1,
		ST_DUPLICATE    = 4'd2,
		ST_FULL         = 4'd3,
		ST_FOUND        = 4'd4,
		ST_NOT_FOUND    = 4'd5,
		ST_REMOVED      = 4'd6,
		ST_EXPIRED      = 4'd7,
		ST_NONE_EXPIRED = 4'd8
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  entry_index;
		logic [63:0] entry_name;
		logic [31:0] entry_nonce;
		logic [7:0]  face_out;
		logic [1:0]  face_position;
		logic [2:0]  face_count;
		logic [4:0]  occupancy;
		logic        last;
	} res_t;

	typedef struct packed {
		logic eq;
		logic le;
	} cmp_res_t;

endpackage

@@ rtl/core/pit_cmp.sv @@
// Shared compare unit: equality and unsigned less-or-equal.
`timescale 1ns / 1ps
module pit_cmp (
	input  logic [pit_pkg::CMP_W-1:0] a,
	input  logic [pit_pkg::CMP_W-1:0] b,
	output pit_pkg::cmp_res_t         res
);
	import pit_pkg::*;

	assign res.eq = (a == b);
	assign res.le = (a <= b);

endmodule

@@ rtl/core/pit_entry_mem.sv @@
// Entry storage: key, nonce, expiry and face count per entry.
`timescale 1ns / 1ps
module pit_entry_mem #(
	parameter int ENTRIES = 16,
	parameter int KEY_W = 64,
	parameter int IDX_W = 4,
	parameter int CNT_W = 3
) (
	input  logic             clk,
	input  logic             we_all,
	input  logic             we_cnt,
	input  logic [IDX_W-1:0] waddr,
	input  logic [KEY_W-1:0] wkey,
	input  logic [31:0]      wnonce,
	input  logic [31:0]      wexp,
	input  logic [CNT_W-1:0] wcnt,
	input  logic [IDX_W-1:0] raddr,
	output logic [KEY_W-1:0] rkey,
	output logic [31:0]      rnonce,
	output logic [31:0]      rexp,
	output logic [CNT_W-1:0] rcnt
);
	import pit_pkg::*;

	logic [KEY_W-1:0] key_mem [ENTRIES];
	logic [31:0]      nonce_mem [ENTRIES];
	logic [31:0]      exp_mem [ENTRIES];
	logic [CNT_W-1:0] cnt_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we_all) begin
			key_mem[waddr] <= wkey;
			nonce_mem[waddr] <= wnonce;
			exp_mem[waddr] <= wexp;
		end
		if (we_all || we_cnt) begin
			cnt_mem[waddr] <= wcnt;
		end
		rkey <= key_mem[raddr];
		rnonce <= nonce_mem[raddr];
		rexp <= exp_mem[raddr];
		rcnt <= cnt_mem[raddr];
	end

endmodule

@@ rtl/core/pit_face_mem.sv @@
// Face slot storage, addressed by entry and slot.
`timescale 1ns / 1ps
module pit_face_mem #(
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);
	import pit_pkg::*;

	logic [7:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/pending_interest_table_top.sv @@
// Top level of the pending request table: sequencer, valid bits and result register.
`timescale 1ns / 1ps
// Usage:
//  Command channel: drive command and its fields with start; the command is
//  taken at a rising edge with start high and busy low. busy stays high until
//  the last result of that command has been issued.
//  Result channel: each result is shown for one cycle with result_valid high;
//  last marks the final result of a command. The receiver cannot stall.
// Command flow (N = TABLE_ENTRIES):
//  Every command first walks all N entries through one registered memory
//  read port and the shared compare unit to reach the decision.
//  Insert new/full, remove, duplicate: result in the cycle after the decision.
//  Aggregating insert then walks the faces of the entry. Lookup emits one
//  face per cycle once the face reads have begun.
//  Sweep walks the table twice (count, then free), with expired entries
//  reported as they are reached in the second walk.
// Reset: arst_n clears the valid bits and occupancy; all entries are free.
module pending_interest_table_top #(
	parameter int TABLE_ENTRIES = 16,
	parameter int FACES_PER_ENTRY = 4,
	parameter int KEY_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [63:0] name_key,
	input  logic [31:0] request_nonce,
	input  logic [7:0]  face_id,
	input  logic [31:0] lifetime_ms,
	input  logic [31:0] now_ms,
	output logic        result_valid,
	output logic [3:0]  status,
	output logic [3:0]  entry_index,
	output logic [63:0] entry_name,
	output logic [31:0] entry_nonce,
	output logic [7:0]  face_out,
	output logic [1:0]  face_position,
	output logic [2:0]  face_count,
	output logic [4:0]  occupancy,
	output logic        last
);
	import pit_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int JW = (FACES_PER_ENTRY > 1) ? $clog2(FACES_PER_ENTRY) : 1;
	localparam int FCW = $clog2(FACES_PER_ENTRY + 1);
	localparam int FCW1 = FCW + 1;
	localparam int FAW = IW + JW;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_DECIDE = 6'b000100,
		S_FSCAN  = 6'b001000,
		S_FWRITE = 6'b010000,
		S_SWEEP  = 6'b100000
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [31:0] nonce_q, exp_q, now_q;
	logic [7:0] face_q;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CW-1:0] cnt_q, exp_cnt_q, iss_q;
	logic [4:0] rep_q;
	logic found_q, free_q, present_q;
	logic [IW-1:0] fidx_q, free_idx_q, idx_s1;
	logic [31:0] fnonce_q;
	logic [FCW-1:0] fcnt_q, fiss_q;
	logic vld_s1, fvld_s1;
	logic [JW-1:0] fj_s1;

	logic [KEY_BITS-1:0] key_rd;
	logic [31:0] nonce_rd, exp_rd;
	logic [FCW-1:0] ecnt_rd;
	logic [7:0] face_rd;

	logic ent_we, cnt_we, face_we;
	logic [IW-1:0] ent_waddr;
	logic [FCW-1:0] ent_wcnt;
	logic [FAW-1:0] face_waddr;

	logic [CMP_W-1:0] cmp_a, cmp_b;
	cmp_res_t cmp;

	logic accept, scanning, scan_done, entry_hit, flast, add_face;
	logic [32:0] sum33;
	logic [7:0] rep_n;
	logic emit;
	res_t res_d, res_q;
	logic rv_q;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign scanning = (state_q == S_SCAN) || (state_q == S_SWEEP);
	assign sum33 = {1'b0, now_ms} + {1'b0, lifetime_ms};
	assign scan_done = vld_s1 && (CW'(idx_s1) == CW'(TABLE_ENTRIES - 1));
	assign flast = (FCW1'(fj_s1) + FCW1'(1)) == FCW1'(fcnt_q);
	assign add_face = !present_q && (FCW1'(fcnt_q) < FCW1'(FACES_PER_ENTRY));
	assign rep_n = (8'(exp_cnt_q) > 8'(MAX_RESULTS)) ? 8'(MAX_RESULTS) : 8'(exp_cnt_q);

	// Operand select for the shared compare unit.
	always_comb begin
		cmp_a = CMP_W'(key_rd);
		cmp_b = CMP_W'(key_q);
		if (state_q == S_FSCAN) begin
			cmp_a = CMP_W'(face_rd);
			cmp_b = CMP_W'(face_q);
		end else if (state_q == S_DECIDE) begin
			cmp_a = CMP_W'(fnonce_q);
			cmp_b = CMP_W'(nonce_q);
		end else if (cmd_q == CMD_SWEEP) begin
			cmp_a = CMP_W'(exp_rd);
			cmp_b = CMP_W'(now_q);
		end
	end

	pit_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	assign entry_hit = vld_s1 && valid_q[idx_s1] && ((cmd_q == CMD_SWEEP) ? cmp.le : cmp.eq);

	// Memory write controls.
	always_comb begin
		ent_we = 1'b0;
		cnt_we = 1'b0;
		face_we = 1'b0;
		ent_waddr = free_idx_q;
		ent_wcnt = FCW'(1);
		face_waddr = {free_idx_q, JW'(0)};
		if (state_q == S_DECIDE && cmd_q == CMD_INSERT && !found_q && free_q) begin
			ent_we = 1'b1;
			face_we = 1'b1;
		end else if (state_q == S_FWRITE && add_face) begin
			cnt_we = 1'b1;
			face_we = 1'b1;
			ent_waddr = fidx_q;
			ent_wcnt = fcnt_q + FCW'(1);
			face_waddr = {fidx_q, fcnt_q[JW-1:0]};
		end
	end

	pit_entry_mem #(
		.ENTRIES (TABLE_ENTRIES),
		.KEY_W   (KEY_BITS),
		.IDX_W   (IW),
		.CNT_W   (FCW)
	) u_entry_mem (
		.clk    (clk),
		.we_all (ent_we),
		.we_cnt (cnt_we),
		.waddr  (ent_waddr),
		.wkey   (key_q),
		.wnonce (nonce_q),
		.wexp   (exp_q),
		.wcnt   (ent_wcnt),
		.raddr  (iss_q[IW-1:0]),
		.rkey   (key_rd),
		.rnonce (nonce_rd),
		.rexp   (exp_rd),
		.rcnt   (ecnt_rd)
	);

	pit_face_mem #(
		.ADDR_W (FAW)
	) u_face_mem (
		.clk   (clk),
		.we    (face_we),
		.waddr (face_waddr),
		.wdata (face_q),
		.raddr ({fidx_q, fiss_q[JW-1:0]}),
		.rdata (face_rd)
	);

	// Result formation.
	always_comb begin
		emit = 1'b0;
		res_d = '0;
		res_d.occupancy = 5'(cnt_q);
		res_d.last = 1'b1;
		unique case (state_q)
			S_DECIDE: begin
				case (cmd_q) inside
					CMD_INSERT: begin
						if (found_q) begin
							if (cmp.eq) begin
								emit = 1'b1;
								res_d.status = ST_DUPLICATE;
								res_d.entry_index = 4'(fidx_q);
								res_d.entry_name = 64'(key_q);
								res_d.entry_nonce = fnonce_q;
								res_d.face_count = 3'(fcnt_q);
							end
						end else if (free_q) begin
							emit = 1'b1;
							res_d.status = ST_NEW;
							res_d.entry_index = 4'(free_idx_q);
							res_d.entry_name = 64'(key_q);
							res_d.entry_nonce = nonce_q;
							res_d.face_count = 3'd1;
							res_d.occupancy = 5'(cnt_q + CW'(1));
						end else begin
							emit = 1'b1;
							res_d.status = ST_FULL;
						end
					end
					CMD_LOOKUP, CMD_REMOVE: begin
						if (!found_q) begin
							emit = 1'b1;
							res_d.status = ST_NOT_FOUND;
						end else if (cmd_q == CMD_REMOVE) begin
							emit = 1'b1;
							res_d.status = ST_REMOVED;
							res_d.entry_index = 4'(fidx_q);
							res_d.entry_name = 64'(key_q);
							res_d.entry_nonce = fnonce_q;
							res_d.occupancy = 5'(cnt_q - CW'(1));
						end else if (fcnt_q == '0) begin
							emit = 1'b1;
							res_d.status = ST_FOUND;
							res_d.entry_index = 4'(fidx_q);
							res_d.entry_name = 64'(key_q);
							res_d.entry_nonce = fnonce_q;
						end
					end
					default: begin
						if (exp_cnt_q == '0) begin
							emit = 1'b1;
							res_d.status = ST_NONE_EXPIRED;
						end
					end
				endcase
			end
			S_FSCAN: begin
				if (fvld_s1 && cmd_q == CMD_LOOKUP) begin
					emit = 1'b1;
					res_d.status = ST_FOUND;
					res_d.entry_index = 4'(fidx_q);
					res_d.entry_name = 64'(key_q);
					res_d.entry_nonce = fnonce_q;
					res_d.face_out = face_rd;
					res_d.face_position = 2'(fj_s1);
					res_d.face_count = 3'(fcnt_q);
					res_d.last = flast;
				end
			end
			S_FWRITE: begin
				emit = 1'b1;
				res_d.status = ST_AGGREGATED;
				res_d.entry_index = 4'(fidx_q);
				res_d.entry_name = 64'(key_q);
				res_d.entry_nonce = fnonce_q;
				res_d.face_count = add_face ? 3'(fcnt_q + FCW'(1)) : 3'(fcnt_q);
			end
			S_SWEEP: begin
				if (entry_hit && rep_q < 5'(MAX_RESULTS)) begin
					emit = 1'b1;
					res_d.status = ST_EXPIRED;
					res_d.entry_index = 4'(idx_s1);
					res_d.entry_name = 64'(key_rd);
					res_d.entry_nonce = nonce_rd;
					res_d.occupancy = 5'(cnt_q - exp_cnt_q);
					res_d.last = (8'(rep_q) + 8'd1) == rep_n;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			cnt_q <= '0;
			rv_q <= 1'b0;
			vld_s1 <= 1'b0;
			fvld_s1 <= 1'b0;
			iss_q <= '0;
			fiss_q <= '0;
		end else begin
			rv_q <= emit;
			vld_s1 <= scanning && (iss_q != CW'(TABLE_ENTRIES));
			fvld_s1 <= (state_q == S_FSCAN) && (fiss_q != fcnt_q);
			if (scanning && iss_q != CW'(TABLE_ENTRIES)) begin
				iss_q <= iss_q + CW'(1);
			end
			if (state_q == S_FSCAN && fiss_q != fcnt_q) begin
				fiss_q <= fiss_q + FCW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						iss_q <= '0;
						found_q <= 1'b0;
						free_q <= 1'b0;
						exp_cnt_q <= '0;
						rep_q <= '0;
					end
				end
				S_SCAN: begin
					if (entry_hit) begin
						if (cmd_q == CMD_SWEEP) begin
							exp_cnt_q <= exp_cnt_q + CW'(1);
						end else if (!found_q) begin
							found_q <= 1'b1;
							fidx_q <= idx_s1;
							fnonce_q <= nonce_rd;
							fcnt_q <= ecnt_rd;
						end
					end
					if (vld_s1 && !valid_q[idx_s1] && !free_q) begin
						free_q <= 1'b1;
						free_idx_q <= idx_s1;
					end
					if (scan_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_IDLE;
					fiss_q <= '0;
					present_q <= 1'b0;
					case (cmd_q)
						CMD_INSERT: begin
							if (found_q) begin
								if (!cmp.eq) begin
									state_q <= (fcnt_q == '0) ? S_FWRITE : S_FSCAN;
								end
							end else if (free_q) begin
								valid_q[free_idx_q] <= 1'b1;
								cnt_q <= cnt_q + CW'(1);
							end
						end
						CMD_LOOKUP: begin
							if (found_q && fcnt_q != '0) begin
								state_q <= S_FSCAN;
							end
						end
						CMD_REMOVE: begin
							if (found_q) begin
								valid_q[fidx_q] <= 1'b0;
								cnt_q <= cnt_q - CW'(1);
							end
						end
						default: begin
							if (exp_cnt_q != '0) begin
								state_q <= S_SWEEP;
								iss_q <= '0;
							end
						end
					endcase
				end
				S_FSCAN: begin
					if (fvld_s1) begin
						if (cmp.eq) begin
							present_q <= 1'b1;
						end
						if (flast) begin
							state_q <= (cmd_q == CMD_INSERT) ? S_FWRITE : S_IDLE;
						end
					end
				end
				S_FWRITE: begin
					state_q <= S_IDLE;
				end
				S_SWEEP: begin
					if (entry_hit) begin
						valid_q[idx_s1] <= 1'b0;
					end
					if (emit) begin
						rep_q <= rep_q + 5'd1;
					end
					if (scan_done) begin
						cnt_q <= cnt_q - exp_cnt_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command capture and per-command scratch; payload needs no reset.
	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[IW-1:0];
		fj_s1 <= fiss_q[JW-1:0];
		res_q <= res_d;
		if (accept) begin
			cmd_q <= cmd_t'(command);
			key_q <= name_key[KEY_BITS-1:0];
			nonce_q <= request_nonce;
			face_q <= face_id;
			now_q <= now_ms;
			exp_q <= sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
		end
	end

	assign result_valid = rv_q;
	assign status = res_q.status;
	assign entry_index = res_q.entry_index;
	assign entry_name = res_q.entry_name;
	assign entry_nonce = res_q.entry_nonce;
	assign face_out = res_q.face_out;
	assign face_position = res_q.face_position;
	assign face_count = res_q.face_count;
	assign occupancy = res_q.occupancy;
	assign last = res_q.last;

`include "pending_interest_table_top_macros.svh"

	`PIT_ASSERT_NOW(a_occ_matches_valid, state_q == S_IDLE, cnt_q == CW'($countones(valid_q)), "occupancy out of step with valid bits")
	`PIT_ASSERT_NEXT(a_accept_busy, accept, busy, "command taken but block not busy")
	`PIT_ASSERT_NOW(a_more_results_busy, result_valid && !last, busy, "result stream cut short")

endmodule
